// ----- rtl/rru_pkg.sv -----
// shared types, formats and curve constants for the relaxed reluctivity update
package rru_pkg;

  localparam int FLUX_W        = 24;
  localparam int NU_W          = 32;
  localparam int FLUX_FRAC_DEF = 20;
  localparam int NU_FRAC_DEF   = 12;

  // square root of gx^2 + gy^2
  localparam int RAD_W      = 48;
  localparam int ROOT_W     = 24;
  localparam int SQ_REM_W   = 28;
  localparam int SQRT_CELLS = ROOT_W;

  // flux in q.20, series argument in q.24
  localparam int B20_W = 32;
  localparam int X_W   = 28;

  // theta * 2^20 / b20, one quotient bit per cell
  localparam int QUOT_W    = 40;
  localparam int DIV_REM_W = 33;
  localparam int DIV_CELLS = QUOT_W;

  // series for (e^x - 1)/x
  localparam int TERM_W       = 35;
  localparam int SUM_W        = 40;
  localparam int FRAC24       = 24;
  localparam int A_W          = TERM_W + X_W - FRAC24;
  localparam int SPLIT        = 20;
  localparam int SERIES_TERMS = 48;
  localparam int TGT_W        = 40;

  localparam logic [31:0]          ALPHA_Q20 = 32'd2178108108;
  localparam logic [26:0]          BETA_Q24  = 27'd88750682;
  localparam logic [TGT_W-1:0]     NU0_Q20   = 40'd834430267582;
  localparam logic [B20_W-1:0]     KNEE_Q20  = 32'd2362518;
  localparam logic [40:0]          THETA_Q20 = 41'd1717798718073;
  localparam logic [DIV_REM_W-1:0] DIV_REM0  = DIV_REM_W'(THETA_Q20[40:20]);
  localparam logic [QUOT_W-1:0]    DIV_NUM0  = {THETA_Q20[19:0], 20'b0};
  localparam logic [TERM_W-1:0]    ONE_Q24   = TERM_W'(64'd1 << FRAC24);

  typedef struct packed {
    logic signed [FLUX_W-1:0] grad_x;
    logic signed [FLUX_W-1:0] grad_y;
    logic [NU_W-1:0]          old_nu;
  } rru_in_t;

  typedef struct packed {
    logic [NU_W-1:0]   new_nu;
    logic [FLUX_W-1:0] flux_magnitude;
    logic              saturated_branch;
    logic              clipped;
  } rru_out_t;

  typedef struct packed {
    logic [RAD_W-1:0]    rad;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [NU_W-1:0]     old_nu;
  } rru_sqrt_t;

  typedef struct packed {
    logic [NU_W-1:0]   old_nu;
    logic [FLUX_W-1:0] flux;
    logic [B20_W-1:0]  b20;
    logic              lin;
    logic [X_W-1:0]    x;
    logic [QUOT_W-1:0] quot;
  } rru_meta_t;

  typedef struct packed {
    rru_meta_t            meta;
    logic [DIV_REM_W-1:0] rem;
    logic [QUOT_W-1:0]    num;
  } rru_div_t;

endpackage

// ----- rtl/rru_sqrt_cell.sv -----
// one root bit of the integer square root per cell
module rru_sqrt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rru_pkg::rru_sqrt_t data_i,
  output logic               valid_o,
  output rru_pkg::rru_sqrt_t data_o
);
  import rru_pkg::*;

  logic                valid_q;
  rru_sqrt_t           data_q, data_d;
  logic [SQ_REM_W-1:0] rem_s, trial;

  always_comb begin
    rem_s  = {data_i.rem[SQ_REM_W-3:0], data_i.rad[RAD_W-1 -: 2]};
    trial  = SQ_REM_W'({data_i.root, 2'b01});
    data_d = data_i;
    data_d.rad = data_i.rad << 2;
    if (rem_s >= trial) begin
      data_d.rem  = rem_s - trial;
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_s;
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/rru_div_cell.sv -----
// one quotient bit of theta * 2^20 / b20 per cell
module rru_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  rru_pkg::rru_div_t data_i,
  output logic              valid_o,
  output rru_pkg::rru_div_t data_o
);
  import rru_pkg::*;

  logic                 valid_q;
  rru_div_t             data_q, data_d;
  logic [DIV_REM_W-1:0] rem_s, dvs;

  always_comb begin
    rem_s  = {data_i.rem[DIV_REM_W-2:0], data_i.num[QUOT_W-1]};
    dvs    = DIV_REM_W'(data_i.meta.b20);
    data_d = data_i;
    data_d.num = data_i.num << 1;
    if (rem_s >= dvs) begin
      data_d.rem       = rem_s - dvs;
      data_d.meta.quot = {data_i.meta.quot[QUOT_W-2:0], 1'b1};
    end else begin
      data_d.rem       = rem_s;
      data_d.meta.quot = {data_i.meta.quot[QUOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/rru_series_cell.sv -----
// one series term: term * x / (DIVISOR * 2^24), accumulated into the sum
module rru_series_cell #(
  parameter int DIVISOR = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  rru_pkg::rru_meta_t         meta_i,
  input  logic [rru_pkg::TERM_W-1:0] term_i,
  input  logic [rru_pkg::SUM_W-1:0]  sum_i,
  output logic                       valid_o,
  output rru_pkg::rru_meta_t         meta_o,
  output logic [rru_pkg::TERM_W-1:0] term_o,
  output logic [rru_pkg::SUM_W-1:0]  sum_o
);
  import rru_pkg::*;

  localparam int     L    = $clog2(DIVISOR);
  localparam int     AH_W = A_W - SPLIT;
  localparam int     T_W  = SPLIT + L;
  localparam longint MH   = ((longint'(1) << (AH_W + L)) + DIVISOR - 1) / DIVISOR;
  localparam longint ML   = ((longint'(1) << (T_W + L)) + DIVISOR - 1) / DIVISOR;
  localparam int     MH_W = AH_W + 2;
  localparam int     ML_W = T_W + 2;

  logic      v1_q, v2_q, v3_q, v4_q;
  rru_meta_t m1_q, m2_q, m3_q, m4_q;
  logic [SUM_W-1:0]  s1_q, s2_q, s3_q, s4_q;
  logic [A_W-1:0]    a1_q;
  logic [AH_W-1:0]   qh2_q, ahi2_q, qh3_q;
  logic [SPLIT-1:0]  alo2_q;
  logic [T_W-1:0]    t3_q;
  logic [TERM_W-1:0] term4_q;

  logic [TERM_W+X_W-1:0] prod1;
  logic [AH_W+MH_W-1:0]  ph2;
  logic [AH_W-1:0]       qh2, qd3, r3;
  logic [T_W+ML_W-1:0]   pl4;
  logic [SPLIT-1:0]      ql4;

  always_comb begin
    prod1 = (TERM_W+X_W)'(term_i) * (TERM_W+X_W)'(meta_i.x);
    ph2   = (AH_W+MH_W)'(a1_q[A_W-1:SPLIT]) * (AH_W+MH_W)'(MH);
    qh2   = AH_W'(ph2 >> (AH_W + L));
    // remainder of the high part is below the divisor
    qd3   = qh2_q * AH_W'(DIVISOR);
    r3    = ahi2_q - qd3;
    pl4   = (T_W+ML_W)'(t3_q) * (T_W+ML_W)'(ML);
    ql4   = SPLIT'(pl4 >> (T_W + L));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= meta_i;
      s1_q    <= sum_i + SUM_W'(term_i);
      a1_q    <= prod1[TERM_W+X_W-1:FRAC24];
      m2_q    <= m1_q;
      s2_q    <= s1_q;
      qh2_q   <= qh2;
      ahi2_q  <= a1_q[A_W-1:SPLIT];
      alo2_q  <= a1_q[SPLIT-1:0];
      m3_q    <= m2_q;
      s3_q    <= s2_q;
      qh3_q   <= qh2_q;
      t3_q    <= {r3[L-1:0], alo2_q};
      m4_q    <= m3_q;
      s4_q    <= s3_q;
      term4_q <= TERM_W'({qh3_q, ql4});
    end
  end

  assign valid_o = v4_q;
  assign meta_o  = m4_q;
  assign term_o  = term4_q;
  assign sum_o   = s4_q;

endmodule

// ----- rtl/reluctivity_relaxed_update.sv -----
// top level: magnitude, material curve and relaxed reluctivity pipeline
// structure: 24 root cells, 40 divider cells, 47 four-stage series cells,
//   plus front, back and output registers
// throughput: one word per cycle while the input is not stalled; every cell stage advances together
// a two-entry output register with skid parts the stall of the two sides
// reset clears the valid bits only; data registers are not reset
module reluctivity_relaxed_update #(
  parameter int FLUX_FRAC_BITS = rru_pkg::FLUX_FRAC_DEF,
  parameter int NU_FRAC_BITS   = rru_pkg::NU_FRAC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rru_pkg::rru_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rru_pkg::rru_out_t out_data_o
);
  import rru_pkg::*;

  localparam int     FSH_R   = (FLUX_FRAC_BITS >= 20) ? FLUX_FRAC_BITS - 20 : 0;
  localparam int     FSH_L   = (FLUX_FRAC_BITS < 20) ? 20 - FLUX_FRAC_BITS : 0;
  localparam int     NSH     = 20 - NU_FRAC_BITS;
  localparam int     OLD20_W = NU_W + NSH;
  localparam int     S_W     = ((OLD20_W + 4 > TGT_W) ? OLD20_W + 4 : TGT_W) + 1;
  localparam int     DK      = 24;
  localparam int     SH_W    = S_W - DK;
  localparam int     MH_W    = SH_W + 2;
  localparam int     T_W     = DK + 4;
  localparam int     ML_W    = T_W + 2;
  localparam longint MH10    = ((longint'(1) << (SH_W + 4)) + 9) / 10;
  localparam longint ML10    = ((longint'(1) << (T_W + 4)) + 9) / 10;
  localparam int     HALF    = (NSH > 0) ? (1 << (NSH - 1)) : 0;
  localparam int     RES_W   = S_W + 1;

  logic en;
  logic sk_v_q, out_v_q;
  rru_out_t sk_q, out_q, f8_d;

  assign en         = !sk_v_q;
  assign in_stall_o = sk_v_q;

  // front: absolute values, squares, sum
  logic v0_q, v1_q, v2_q;
  logic [FLUX_W-1:0] ax0_q, ay0_q;
  logic [NU_W-1:0]   nu0_q, nu1_q;
  logic [RAD_W-1:0]  sx1_q, sy1_q;
  rru_sqrt_t         sq0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax0_q <= in_data_i.grad_x[FLUX_W-1] ? FLUX_W'(-in_data_i.grad_x)
                                           : FLUX_W'(in_data_i.grad_x);
      ay0_q <= in_data_i.grad_y[FLUX_W-1] ? FLUX_W'(-in_data_i.grad_y)
                                           : FLUX_W'(in_data_i.grad_y);
      nu0_q <= in_data_i.old_nu;
      sx1_q <= RAD_W'(ax0_q) * RAD_W'(ax0_q);
      sy1_q <= RAD_W'(ay0_q) * RAD_W'(ay0_q);
      nu1_q <= nu0_q;
      sq0_q.rad    <= sx1_q + sy1_q;
      sq0_q.rem    <= '0;
      sq0_q.root   <= '0;
      sq0_q.old_nu <= nu1_q;
    end
  end

  // square root chain
  logic      sq_v [SQRT_CELLS+1];
  rru_sqrt_t sq_d [SQRT_CELLS+1];

  assign sq_v[0] = v2_q;
  assign sq_d[0] = sq0_q;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    rru_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .data_i  (sq_d[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq_d[i+1])
    );
  end

  // rescale, knee test, series argument
  logic p1_v_q, p2_v_q;
  rru_meta_t p1_q;
  rru_div_t  p2_q;
  rru_meta_t p2_meta;
  logic [B20_W-1:0] b_ext, b20;
  logic [48:0]      xp;

  always_comb begin
    b_ext = B20_W'(sq_d[SQRT_CELLS].root);
    b20   = (b_ext << FSH_L) >> FSH_R;
    xp    = 49'(p1_q.b20[21:0]) * 49'(BETA_Q24);
    p2_meta = p1_q;
    // linear branch items run the series on zero
    p2_meta.x = p1_q.lin ? '0 : xp[47:20];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= sq_v[SQRT_CELLS];
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q.old_nu <= sq_d[SQRT_CELLS].old_nu;
      p1_q.flux   <= sq_d[SQRT_CELLS].root;
      p1_q.b20    <= b20;
      p1_q.lin    <= (b20 >= KNEE_Q20);
      p1_q.x      <= '0;
      p1_q.quot   <= '0;
      p2_q.meta   <= p2_meta;
      p2_q.rem    <= DIV_REM0;
      p2_q.num    <= DIV_NUM0;
    end
  end

  // divider chain
  logic     dv_v [DIV_CELLS+1];
  rru_div_t dv_d [DIV_CELLS+1];

  assign dv_v[0] = p2_v_q;
  assign dv_d[0] = p2_q;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    rru_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[i]),
      .data_i  (dv_d[i]),
      .valid_o (dv_v[i+1]),
      .data_o  (dv_d[i+1])
    );
  end

  // series chain
  logic              se_v [SERIES_TERMS];
  rru_meta_t         se_m [SERIES_TERMS];
  logic [TERM_W-1:0] se_t [SERIES_TERMS];
  logic [SUM_W-1:0]  se_s [SERIES_TERMS];

  assign se_v[0] = dv_v[DIV_CELLS];
  assign se_m[0] = dv_d[DIV_CELLS].meta;
  assign se_t[0] = ONE_Q24;
  assign se_s[0] = '0;

  for (genvar n = 1; n < SERIES_TERMS; n++) begin : g_series
    rru_series_cell #(
      .DIVISOR (n + 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (se_v[n-1]),
      .meta_i  (se_m[n-1]),
      .term_i  (se_t[n-1]),
      .sum_i   (se_s[n-1]),
      .valid_o (se_v[n]),
      .meta_o  (se_m[n]),
      .term_o  (se_t[n]),
      .sum_o   (se_s[n])
    );
  end

  // back end: target, relaxation, divide by ten, round to q.n
  logic f1_v_q, f2_v_q, f3_v_q, f4_v_q, f5_v_q, f6_v_q, f7_v_q, f8_v_q;
  rru_meta_t f1_m_q, f2_m_q, f3_m_q, f4_m_q, f5_m_q, f6_m_q, f7_m_q;
  logic [SUM_W-1:0]   g1_q;
  logic [58:0]        prod2_q;
  logic [TGT_W-1:0]   tl2_q, tgt3_q;
  logic [S_W-1:0]     s4_q, s5_q;
  logic [SH_W-1:0]    qh5_q, qh6_q;
  logic [T_W-1:0]     t6_q;
  logic [S_W-1:0]     new7_q;
  rru_out_t           f8_q;

  logic [OLD20_W-1:0]   old20;
  logic [SH_W+MH_W-1:0] ph5;
  logic [SH_W-1:0]      qd6, r6;
  logic [T_W+ML_W-1:0]  pl7;
  logic [RES_W-1:0]     rsum8, res8;
  logic                 clip8;

  always_comb begin
    old20 = OLD20_W'(f3_m_q.old_nu) << NSH;
    ph5   = (SH_W+MH_W)'(s4_q[S_W-1:DK]) * (SH_W+MH_W)'(MH10);
    qd6   = qh5_q * SH_W'(10);
    r6    = s5_q[S_W-1:DK] - qd6;
    pl7   = (T_W+ML_W)'(t6_q) * (T_W+ML_W)'(ML10);
    rsum8 = RES_W'(new7_q) + RES_W'(HALF);
    res8  = rsum8 >> NSH;
    clip8 = |res8[RES_W-1:NU_W];
    f8_d.new_nu           = clip8 ? '1 : res8[NU_W-1:0];
    f8_d.flux_magnitude   = f7_m_q.flux;
    f8_d.saturated_branch = f7_m_q.lin;
    f8_d.clipped          = clip8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
      f5_v_q <= 1'b0;
      f6_v_q <= 1'b0;
      f7_v_q <= 1'b0;
      f8_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= se_v[SERIES_TERMS-1];
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      f4_v_q <= f3_v_q;
      f5_v_q <= f4_v_q;
      f6_v_q <= f5_v_q;
      f7_v_q <= f6_v_q;
      f8_v_q <= f7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_m_q  <= se_m[SERIES_TERMS-1];
      g1_q    <= se_s[SERIES_TERMS-1] + SUM_W'(se_t[SERIES_TERMS-1]);
      f2_m_q  <= f1_m_q;
      prod2_q <= 59'(g1_q[SUM_W-1:8]) * 59'(BETA_Q24);
      tl2_q   <= (f1_m_q.quot > NU0_Q20) ? '0 : NU0_Q20 - f1_m_q.quot;
      f3_m_q  <= f2_m_q;
      tgt3_q  <= f2_m_q.lin ? tl2_q : TGT_W'(ALPHA_Q20) + TGT_W'(prod2_q[58:20]);
      f4_m_q  <= f3_m_q;
      s4_q    <= S_W'(old20) * S_W'(9) + S_W'(tgt3_q) + S_W'(5);
      f5_m_q  <= f4_m_q;
      s5_q    <= s4_q;
      qh5_q   <= SH_W'(ph5 >> (SH_W + 4));
      f6_m_q  <= f5_m_q;
      qh6_q   <= qh5_q;
      t6_q    <= {r6[3:0], s5_q[DK-1:0]};
      f7_m_q  <= f6_m_q;
      new7_q  <= {qh6_q, DK'(pl7 >> (T_W + 4))};
      f8_q    <= f8_d;
    end
  end

  // output register with skid
  logic out_free;
  assign out_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (out_free) begin
      if (sk_v_q) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end else begin
        out_v_q <= f8_v_q;
      end
    end else if (en && f8_v_q) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= sk_v_q ? sk_q : f8_q;
    end else if (en && f8_v_q) begin
      sk_q <= f8_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/rru_checker.sv -----
// port-level checks for the relaxed reluctivity update, bound to the top level
module rru_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input rru_pkg::rru_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rru_pkg::rru_out_t out_data_o
);
  import rru_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // the skid only fills when the output side held a stalled word
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without an output stall");

  a_clip_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |-> out_data_o.new_nu == '1)
    else $error("clipped word not at maximum");

  a_lin_flux: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated_branch |-> out_data_o.flux_magnitude != '0)
    else $error("linear branch taken at zero flux");

endmodule

bind reluctivity_relaxed_update rru_checker u_rru_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- bench/tb.sv -----
// self-checking bench for the relaxed reluctivity update pipeline
module tb;
  import rru_pkg::*;

  localparam int N_RANDOM   = 1680;
  localparam int PAUSE_AT   = 900;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 700;
  localparam int DRAIN_WAIT = 320;
  localparam int IDLE_LIMIT = 6000;

  logic     clk_i, rst_ni;
  logic     in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  rru_in_t  in_data_i;
  rru_out_t out_data_o;

  rru_in_t  pending_words[$];
  rru_out_t expected_nu[$];
  int       errors = 0;
  int       words_sent, results_seen, gap_cnt, stall_cnt, hold_cnt, idle_cnt;
  bit       hold_done;

  reluctivity_relaxed_update DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // fixed-point material curve and relaxation at the default formats
  function automatic rru_out_t predict_update(rru_in_t w);
    longint signed   gx, gy;
    longint unsigned ax, ay, v, root, bitv, b20, target, q, x, term, g, old20, new20, res;
    rru_out_t r;
    gx = longint'($signed(w.grad_x));
    gy = longint'($signed(w.grad_y));
    ax = gx < 0 ? -gx : gx;
    ay = gy < 0 ? -gy : gy;
    v = ax * ax + ay * ay;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    b20 = root;
    r.saturated_branch = (b20 >= 64'(KNEE_Q20));
    if (r.saturated_branch) begin
      q = (64'(THETA_Q20) << 20) / b20;
      target = (q > 64'(NU0_Q20)) ? 64'd0 : 64'(NU0_Q20) - q;
    end else begin
      x = (b20 * 64'(BETA_Q24)) >> 20;
      term = 64'd1 << 24;
      g = term;
      for (int n = 1; n < SERIES_TERMS; n++) begin
        term = (term * x) / (64'(n + 1) << 24);
        g += term;
      end
      target = 64'(ALPHA_Q20) + ((64'(BETA_Q24) * (g >> 8)) >> 20);
    end
    old20 = 64'(w.old_nu) << 8;
    new20 = (9 * old20 + target + 5) / 10;
    res = (new20 + 64'd128) >> 8;
    r.clipped = (res > 64'hFFFF_FFFF);
    r.new_nu = r.clipped ? 32'hFFFF_FFFF : res[31:0];
    r.flux_magnitude = root[23:0];
    return r;
  endfunction

  // mostly short gaps, a few long, with gap-free stretches
  function automatic int pick_gap(int phase_cnt);
    int k;
    if ((phase_cnt / 250) % 3 == 1) return 0;
    k = $urandom_range(0, 19);
    if (k < 12) return 0;
    if (k < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [23:0] rand_flux();
    logic [23:0] v;
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      v = 24'($urandom);
    end else if (k < 7) begin
      v = 24'($urandom) & ((24'd1 << $urandom_range(0, 22)) - 24'd1);
      if ($urandom_range(0, 1)) v = -v;
    end else if (k < 9) begin
      v = 24'(KNEE_Q20) + 24'($urandom_range(0, 4000)) - 24'd2000;
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = 24'($urandom_range(0, 3));
    end
    return v;
  endfunction

  task automatic add_word(logic [23:0] gx, logic [23:0] gy, logic [31:0] nu);
    rru_in_t w;
    w.grad_x = gx;
    w.grad_y = gy;
    w.old_nu = nu;
    pending_words.push_back(w);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_cnt    <= 0;
      words_sent <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_nu.push_back(predict_update(in_data_i));
      nxt_valid = in_valid_i;
      if (!in_valid_i || !in_stall_o) begin
        nxt_valid = 1'b0;
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (words_sent == PAUSE_AT && expected_nu.size() != 0) begin
          // sender waits until the pipeline has drained
        end else if (pending_words.size() != 0) begin
          in_data_i  <= pending_words.pop_front();
          nxt_valid  = 1'b1;
          words_sent <= words_sent + 1;
          gap_cnt    <= pick_gap(words_sent);
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    rru_out_t want;
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      stall_cnt    <= 0;
      hold_cnt     <= 0;
      hold_done    <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_nu.size() == 0) begin
          $error("result with no expected word: %p", out_data_o);
          errors++;
        end else begin
          want = expected_nu.pop_front();
          if (out_data_o.new_nu !== want.new_nu) begin
            $error("new_nu: expected %0d got %0d", want.new_nu, out_data_o.new_nu);
            errors++;
          end
          if (out_data_o.flux_magnitude !== want.flux_magnitude) begin
            $error("flux_magnitude: expected %0d got %0d",
                   want.flux_magnitude, out_data_o.flux_magnitude);
            errors++;
          end
          if (out_data_o.saturated_branch !== want.saturated_branch) begin
            $error("saturated_branch: expected %0b got %0b",
                   want.saturated_branch, out_data_o.saturated_branch);
            errors++;
          end
          if (out_data_o.clipped !== want.clipped) begin
            $error("clipped: expected %0b got %0b", want.clipped, out_data_o.clipped);
            errors++;
          end
        end
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        // long hold-off so the pipeline fills and stalls its input
        hold_done   <= 1'b1;
        hold_cnt    <= HOLD_LEN;
        out_stall_i <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_stall_i <= (hold_cnt > 1);
      end else if (stall_cnt > 0) begin
        stall_cnt   <= stall_cnt - 1;
        out_stall_i <= (stall_cnt > 1);
      end else begin
        stall_cnt   <= pick_gap(results_seen + 100);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    logic [31:0] nu;
    rst_ni = 1'b0;
    // zero flux, field extremes, both sides of the knee, nu extremes
    add_word(24'd0, 24'd0, 32'd0);
    add_word(24'd0, 24'd0, 32'hFFFF_FFFF);
    add_word(24'h800000, 24'h800000, 32'hFFFF_FFFF);
    add_word(24'h800000, 24'h800000, 32'd0);
    add_word(24'h7FFFFF, 24'h7FFFFF, 32'h8000_0000);
    add_word(24'h7FFFFF, 24'h800000, 32'd1);
    add_word(24'h800000, 24'd0, 32'd4096);
    add_word(24'd0, 24'h7FFFFF, 32'h7FFF_FFFF);
    add_word(24'd1, 24'd0, 32'd12345);
    add_word(24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
    add_word(24'(KNEE_Q20), 24'd0, 32'd100000);
    add_word(24'(KNEE_Q20) - 24'd1, 24'd0, 32'd100000);
    add_word(24'd0, -24'(KNEE_Q20), 32'hFFFF_FFFF);
    add_word(24'd0, -(24'(KNEE_Q20) - 24'd1), 32'hFFFF_FFFF);
    add_word(24'd1670547, 24'd1670547, 32'd5000000);
    add_word(24'h555555, 24'hAAAAAA, 32'h5555_5555);
    add_word(24'hAAAAAA, 24'h555555, 32'hAAAA_AAAA);
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 7))
        0:       nu = 32'hFFFF_FFFF - $urandom_range(0, 3);
        1:       nu = $urandom_range(0, 3);
        2:       nu = $urandom_range(0, 1 << 24);
        default: nu = $urandom;
      endcase
      add_word(rand_flux(), rand_flux(), nu);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_words.size() == 0 && !in_valid_i && expected_nu.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0 && expected_nu.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rru_pkg.sv
rtl/rru_sqrt_cell.sv
rtl/rru_div_cell.sv
rtl/rru_series_cell.sv
rtl/reluctivity_relaxed_update.sv
rtl/rru_checker.sv
bench/tb.sv
